### design/mtnp_pkg.sv
// shared types and constants for the midi track note pairer
// no dependencies

package mtnp_pkg;

    localparam int KEY_POSITIONS = 2048;
    localparam int POS_W = 11;
    localparam int STACK_DEPTH_DEFAULT = 8;
    localparam int QUEUE_DEPTH = 4;
    localparam int TICK_W = 56;

    localparam logic [2:0] KIND_NOTE  = 3'd0;
    localparam logic [2:0] KIND_TEMPO = 3'd1;
    localparam logic [2:0] KIND_END   = 3'd2;
    localparam logic [2:0] KIND_DROP  = 3'd3;
    localparam logic [2:0] KIND_BAD   = 3'd4;

    localparam logic [7:0] META_EOT   = 8'h2F;
    localparam logic [7:0] META_TEMPO = 8'h51;
    localparam logic [7:0] META_LEAD  = 8'hFF;

    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_CLEAR = 3'd1,
        OP_PUSH  = 3'd2,
        OP_POP   = 3'd3,
        OP_TEMPO = 3'd4,
        OP_END   = 3'd5,
        OP_BAD   = 3'd6
    } op_code_t;

    typedef struct packed {
        op_code_t          code;
        logic [TICK_W-1:0] tick;
        logic [POS_W-1:0]  pos;
        logic [6:0]        vel;
        logic [15:0]       tag;
        logic [23:0]       tempo;
    } op_t;

    typedef enum logic [14:0] {
        PH_DELTA       = 15'b000000000000001,
        PH_STATUS      = 15'b000000000000010,
        PH_OFF_KEY     = 15'b000000000000100,
        PH_OFF_VEL     = 15'b000000000001000,
        PH_ON_KEY      = 15'b000000000010000,
        PH_ON_VEL      = 15'b000000000100000,
        PH_SKIP        = 15'b000000001000000,
        PH_VLEN        = 15'b000000010000000,
        PH_META_TYPE   = 15'b000000100000000,
        PH_TEMPO_LEN   = 15'b000001000000000,
        PH_TEMPO_DATA  = 15'b000010000000000,
        PH_EOT_LEN     = 15'b000100000000000,
        PH_RESYNC      = 15'b001000000000000,
        PH_RESYNC_TAIL = 15'b010000000000000,
        PH_DONE        = 15'b100000000000000
    } phase_t;

    typedef struct packed {
        logic clearing;
        logic popping;
    } back_stat_t;

endpackage

### design/mtnp_front.sv
// byte parser: delta times, running status, meta and sysex skipping
// depends on mtnp_pkg; emits stack and record requests to the queue

module mtnp_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          data_byte,
    input  logic                track_start,
    input  logic [11:0]         track_number,
    input  logic                q_full,
    output logic                q_push,
    output mtnp_pkg::op_t       q_op
);

    mtnp_pkg::phase_t phase_reg, phase_next, ph_e;
    logic [7:0]  rs_reg, rs_next, rs_e;
    logic [55:0] tick_reg, tick_next, tick_e;
    logic [31:0] vlv_reg, vlv_next, vlv_e, vlv_sh;
    logic [31:0] skip_reg, skip_next, skip_e, skip_d;
    logic [23:0] tempo_reg, tempo_next, tempo_e;
    logic [6:0]  key_reg, key_next, key_e;
    logic [1:0]  tcnt_reg, tcnt_next, tcnt_e;
    logic [15:0] hist_reg, hist_next, hist_e;
    logic        acc;
    logic [7:0]  b;

    assign in_ready = !q_full;
    assign acc = in_valid && in_ready;
    assign b = data_byte;

    always_comb
    begin
        if (track_start)
        begin
            ph_e = mtnp_pkg::PH_DELTA;
            rs_e = '0; tick_e = '0; vlv_e = '0; skip_e = '0;
            tempo_e = '0; key_e = '0; tcnt_e = '0; hist_e = '0;
        end
        else
        begin
            ph_e = phase_reg;
            rs_e = rs_reg; tick_e = tick_reg; vlv_e = vlv_reg; skip_e = skip_reg;
            tempo_e = tempo_reg; key_e = key_reg; tcnt_e = tcnt_reg; hist_e = hist_reg;
        end
        phase_next = ph_e;
        rs_next = rs_e; tick_next = tick_e; vlv_next = vlv_e; skip_next = skip_e;
        tempo_next = tempo_e; key_next = key_e; tcnt_next = tcnt_e; hist_next = hist_e;
        vlv_sh = {vlv_e[24:0], b[6:0]};
        skip_d = (skip_e != 32'd0) ? skip_e - 32'd1 : 32'd0;
        q_op.code  = track_start ? mtnp_pkg::OP_CLEAR : mtnp_pkg::OP_NONE;
        q_op.tick  = tick_e;
        q_op.pos   = {rs_e[3:0], key_e};
        q_op.vel   = b[6:0];
        q_op.tag   = {track_number, rs_e[3:0]};
        q_op.tempo = tempo_e;
        case (ph_e)
            mtnp_pkg::PH_DELTA:
            begin
                vlv_next = vlv_sh;
                if (!b[7])
                begin
                    tick_next = tick_e + {24'd0, vlv_sh};
                    vlv_next = '0;
                    phase_next = mtnp_pkg::PH_STATUS;
                end
            end
            mtnp_pkg::PH_STATUS:
            begin
                if (b[7:4] == 4'h8)
                begin
                    rs_next = b;
                    phase_next = mtnp_pkg::PH_OFF_KEY;
                end
                else if (b[7:4] == 4'h9)
                begin
                    rs_next = b;
                    phase_next = mtnp_pkg::PH_ON_KEY;
                end
                else if (b[7:4] == 4'hA || b[7:4] == 4'hB || b[7:4] == 4'hE)
                begin
                    rs_next = b;
                    skip_next = 32'd2;
                    phase_next = mtnp_pkg::PH_SKIP;
                end
                else if (b[7:4] == 4'hC || b[7:4] == 4'hD)
                begin
                    rs_next = b;
                    skip_next = 32'd1;
                    phase_next = mtnp_pkg::PH_SKIP;
                end
                else if (b[7:4] == 4'hF && !b[3])
                begin
                    rs_next = '0;
                    vlv_next = '0;
                    phase_next = mtnp_pkg::PH_VLEN;
                end
                else if (b == mtnp_pkg::META_LEAD)
                begin
                    rs_next = '0;
                    phase_next = mtnp_pkg::PH_META_TYPE;
                end
                else if (rs_e[7:4] == 4'h8)
                begin
                    key_next = b[6:0];
                    phase_next = mtnp_pkg::PH_OFF_VEL;
                end
                else if (rs_e[7:4] == 4'h9)
                begin
                    key_next = b[6:0];
                    phase_next = mtnp_pkg::PH_ON_VEL;
                end
                else if (rs_e[7:4] == 4'hA || rs_e[7:4] == 4'hB || rs_e[7:4] == 4'hE)
                begin
                    skip_next = 32'd1;
                    phase_next = mtnp_pkg::PH_SKIP;
                end
                else if (rs_e[7:4] == 4'hC || rs_e[7:4] == 4'hD)
                begin
                    phase_next = mtnp_pkg::PH_DELTA;
                end
                else
                begin
                    hist_next = '0;
                    phase_next = mtnp_pkg::PH_RESYNC;
                end
            end
            mtnp_pkg::PH_OFF_KEY, mtnp_pkg::PH_ON_KEY:
            begin
                key_next = b[6:0];
                phase_next = (ph_e == mtnp_pkg::PH_ON_KEY) ? mtnp_pkg::PH_ON_VEL
                                                           : mtnp_pkg::PH_OFF_VEL;
            end
            mtnp_pkg::PH_OFF_VEL:
            begin
                q_op.code = mtnp_pkg::OP_POP;
                phase_next = mtnp_pkg::PH_DELTA;
            end
            mtnp_pkg::PH_ON_VEL:
            begin
                q_op.code = (b[6:0] != 7'd0) ? mtnp_pkg::OP_PUSH : mtnp_pkg::OP_POP;
                phase_next = mtnp_pkg::PH_DELTA;
            end
            mtnp_pkg::PH_SKIP:
            begin
                skip_next = skip_d;
                if (skip_d == 32'd0)
                    phase_next = mtnp_pkg::PH_DELTA;
            end
            mtnp_pkg::PH_VLEN:
            begin
                vlv_next = vlv_sh;
                if (!b[7])
                begin
                    skip_next = vlv_sh;
                    vlv_next = '0;
                    phase_next = (vlv_sh != 32'd0) ? mtnp_pkg::PH_SKIP : mtnp_pkg::PH_DELTA;
                end
            end
            mtnp_pkg::PH_META_TYPE:
            begin
                if (b == mtnp_pkg::META_EOT)
                begin
                    vlv_next = '0;
                    phase_next = mtnp_pkg::PH_EOT_LEN;
                end
                else if (b == mtnp_pkg::META_TEMPO)
                    phase_next = mtnp_pkg::PH_TEMPO_LEN;
                else
                begin
                    vlv_next = '0;
                    phase_next = mtnp_pkg::PH_VLEN;
                end
            end
            mtnp_pkg::PH_TEMPO_LEN:
            begin
                tempo_next = '0;
                tcnt_next = '0;
                phase_next = mtnp_pkg::PH_TEMPO_DATA;
            end
            mtnp_pkg::PH_TEMPO_DATA:
            begin
                tempo_next = {tempo_e[15:0], b};
                tcnt_next = tcnt_e + 2'd1;
                if (tcnt_e == 2'd2)
                begin
                    q_op.code = mtnp_pkg::OP_TEMPO;
                    q_op.tempo = {tempo_e[15:0], b};
                    tcnt_next = '0;
                    phase_next = mtnp_pkg::PH_DELTA;
                end
            end
            mtnp_pkg::PH_EOT_LEN:
            begin
                vlv_next = vlv_sh;
                if (!b[7])
                begin
                    vlv_next = '0;
                    q_op.code = mtnp_pkg::OP_END;
                    phase_next = mtnp_pkg::PH_DONE;
                end
            end
            mtnp_pkg::PH_RESYNC:
            begin
                if (hist_e == 16'h00FF && b == mtnp_pkg::META_EOT)
                    phase_next = mtnp_pkg::PH_RESYNC_TAIL;
                hist_next = {hist_e[7:0], b};
            end
            mtnp_pkg::PH_RESYNC_TAIL:
            begin
                q_op.code = mtnp_pkg::OP_BAD;
                phase_next = mtnp_pkg::PH_DONE;
            end
            default:
            begin
                phase_next = mtnp_pkg::PH_DONE;
            end
        endcase
    end

    assign q_push = acc && (q_op.code != mtnp_pkg::OP_NONE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= mtnp_pkg::PH_DELTA;
            rs_reg <= '0; tick_reg <= '0; vlv_reg <= '0; skip_reg <= '0;
            tempo_reg <= '0; key_reg <= '0; tcnt_reg <= '0; hist_reg <= '0;
        end
        else if (acc)
        begin
            phase_reg <= phase_next;
            rs_reg <= rs_next; tick_reg <= tick_next; vlv_reg <= vlv_next;
            skip_reg <= skip_next; tempo_reg <= tempo_next; key_reg <= key_next;
            tcnt_reg <= tcnt_next; hist_reg <= hist_next;
        end
    end

endmodule

### design/mtnp_queue.sv
// short request queue between parser and stack engine
// depends on mtnp_pkg

module mtnp_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  mtnp_pkg::op_t       din,
    input  logic                pop,
    output mtnp_pkg::op_t       dout,
    output logic                full,
    output logic                empty,
    output logic [$clog2(mtnp_pkg::QUEUE_DEPTH+1)-1:0] count
);

    localparam int AW = $clog2(mtnp_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(mtnp_pkg::QUEUE_DEPTH + 1);

    mtnp_pkg::op_t ent_reg [mtnp_pkg::QUEUE_DEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [CW-1:0] cnt_reg;
    logic          do_push, do_pop;

    assign full = (cnt_reg == CW'(mtnp_pkg::QUEUE_DEPTH));
    assign empty = (cnt_reg == '0);
    assign count = cnt_reg;
    assign dout = ent_reg[rp_reg];
    assign do_push = push && !full;
    assign do_pop = pop && !empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
            ent_reg[wp_reg] <= din;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
                wp_reg <= (wp_reg == AW'(mtnp_pkg::QUEUE_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            if (do_pop)
                rp_reg <= (rp_reg == AW'(mtnp_pkg::QUEUE_DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

### design/mtnp_back.sv
// stack engine: per channel and key ring stacks, fill memory sweep, result register
// depends on mtnp_pkg; takes requests from mtnp_queue

module mtnp_back
#(
    parameter int STACK_DEPTH = mtnp_pkg::STACK_DEPTH_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  mtnp_pkg::op_t       q_op,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [2:0]          kind,
    output logic [55:0]         start_tick,
    output logic [31:0]         length,
    output logic [7:0]          key,
    output logic [6:0]          velocity,
    output logic [15:0]         track_tag,
    output mtnp_pkg::back_stat_t stat
);

    localparam int PW = mtnp_pkg::POS_W;
    localparam int HW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int FW = $clog2(STACK_DEPTH + 1);
    localparam int WW = HW + FW;
    localparam logic [FW-1:0] DEPTH_F = FW'(STACK_DEPTH);
    localparam logic [HW:0]   DEPTH_S = (HW+1)'(STACK_DEPTH);

    logic [WW-1:0] fill_mem [mtnp_pkg::KEY_POSITIONS];
    logic [62:0]   note_mem [mtnp_pkg::KEY_POSITIONS * (2 ** HW)];

    logic [WW-1:0] fill_rd_reg;
    logic [62:0]   note_rd_reg;
    logic          clearing_reg;
    logic [PW-1:0] clr_cnt_reg;
    logic          s1_valid_reg;
    mtnp_pkg::op_t s1_op_reg;
    logic          fw_valid_reg;
    logic [PW-1:0] fw_pos_reg;
    logic [WW-1:0] fw_val_reg;
    logic          s2_valid_reg;
    logic [2:0]    s2_kind_reg;
    logic [55:0]   s2_tick_reg;
    logic [15:0]   s2_tag_reg;
    logic [23:0]   s2_tempo_reg;
    logic [6:0]    s2_key_reg;

    logic          adv, s1_clear, fill_we, note_we, note_re, emit;
    logic [2:0]    emit_kind;
    logic [WW-1:0] cur, new_val;
    logic [HW-1:0] head, idx, head_inc;
    logic [FW-1:0] cnt;
    logic [HW:0]   sum_pop, sum_push;
    logic [55:0]   mem_start;

    assign adv = !s2_valid_reg || out_ready;
    assign s1_clear = s1_valid_reg && (s1_op_reg.code == mtnp_pkg::OP_CLEAR);
    assign q_pop = q_valid && adv && !clearing_reg && !s1_clear;
    assign stat.clearing = clearing_reg;
    assign stat.popping = q_pop;

    always_comb
    begin
        cur = (fw_valid_reg && fw_pos_reg == s1_op_reg.pos) ? fw_val_reg : fill_rd_reg;
        head = cur[WW-1:FW];
        cnt = cur[FW-1:0];
        sum_pop = {1'b0, head} + (HW+1)'(cnt) - (HW+1)'(1);
        if (sum_pop >= DEPTH_S)
            sum_pop = sum_pop - DEPTH_S;
        sum_push = {1'b0, head} + (HW+1)'(cnt);
        if (sum_push >= DEPTH_S)
            sum_push = sum_push - DEPTH_S;
        head_inc = ({1'b0, head} == DEPTH_S - (HW+1)'(1)) ? '0 : head + 1'b1;
        fill_we = 1'b0;
        note_we = 1'b0;
        note_re = 1'b0;
        emit = 1'b0;
        emit_kind = mtnp_pkg::KIND_NOTE;
        idx = head;
        new_val = cur;
        case (s1_op_reg.code)
            mtnp_pkg::OP_PUSH:
            begin
                fill_we = 1'b1;
                note_we = 1'b1;
                if (cnt >= DEPTH_F)
                begin
                    note_re = 1'b1;
                    emit = 1'b1;
                    emit_kind = mtnp_pkg::KIND_DROP;
                    new_val = {head_inc, DEPTH_F};
                end
                else
                begin
                    idx = sum_push[HW-1:0];
                    new_val = {head, cnt + 1'b1};
                end
            end
            mtnp_pkg::OP_POP:
            begin
                if (cnt != '0)
                begin
                    fill_we = 1'b1;
                    note_re = 1'b1;
                    emit = 1'b1;
                    idx = sum_pop[HW-1:0];
                    new_val = {head, cnt - 1'b1};
                end
            end
            mtnp_pkg::OP_TEMPO:
            begin
                emit = 1'b1;
                emit_kind = mtnp_pkg::KIND_TEMPO;
            end
            mtnp_pkg::OP_END:
            begin
                emit = 1'b1;
                emit_kind = mtnp_pkg::KIND_END;
            end
            mtnp_pkg::OP_BAD:
            begin
                emit = 1'b1;
                emit_kind = mtnp_pkg::KIND_BAD;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    // fill memory: request read on queue pop, write from stage one or the sweep
    always_ff @(posedge clk)
    begin
        if (q_pop)
            fill_rd_reg <= fill_mem[q_op.pos];
        if (clearing_reg)
            fill_mem[clr_cnt_reg] <= '0;
        else if (adv && s1_valid_reg && fill_we)
            fill_mem[s1_op_reg.pos] <= new_val;
    end

    // note memory: read returns the old entry when the same slot is overwritten
    always_ff @(posedge clk)
    begin
        if (adv && s1_valid_reg)
        begin
            if (note_re)
                note_rd_reg <= note_mem[{s1_op_reg.pos, idx}];
            if (note_we)
                note_mem[{s1_op_reg.pos, idx}] <= {s1_op_reg.vel, s1_op_reg.tick};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_op_reg <= q_op;
            fw_pos_reg <= s1_op_reg.pos;
            fw_val_reg <= new_val;
            s2_kind_reg <= emit_kind;
            s2_tick_reg <= s1_op_reg.tick;
            s2_tag_reg <= s1_op_reg.tag;
            s2_tempo_reg <= s1_op_reg.tempo;
            s2_key_reg <= s1_op_reg.pos[6:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_cnt_reg <= '0;
            s1_valid_reg <= 1'b0;
            fw_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (clearing_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == PW'(mtnp_pkg::KEY_POSITIONS - 1))
                    clearing_reg <= 1'b0;
            end
            if (adv)
            begin
                s1_valid_reg <= q_pop;
                s2_valid_reg <= s1_valid_reg && emit;
                // forward only the fill word written at this edge
                fw_valid_reg <= s1_valid_reg && fill_we;
                if (s1_clear)
                begin
                    clearing_reg <= 1'b1;
                    clr_cnt_reg <= '0;
                end
            end
        end
    end

    assign mem_start = note_rd_reg[55:0];
    assign out_valid = s2_valid_reg;
    assign kind = s2_kind_reg;

    always_comb
    begin
        start_tick = s2_tick_reg;
        length = '0;
        key = '0;
        velocity = '0;
        track_tag = '0;
        case (s2_kind_reg)
            mtnp_pkg::KIND_NOTE, mtnp_pkg::KIND_DROP:
            begin
                start_tick = mem_start;
                if (s2_kind_reg == mtnp_pkg::KIND_NOTE)
                    length = s2_tick_reg[31:0] - mem_start[31:0];
                key = {1'b0, s2_key_reg};
                velocity = note_rd_reg[62:56];
                track_tag = s2_tag_reg;
            end
            mtnp_pkg::KIND_TEMPO:
            begin
                length = {8'd0, s2_tempo_reg};
                key = 8'hFF;
            end
            default:
            begin
                length = '0;
            end
        endcase
    end

endmodule

### design/midi_track_note_pairer.sv
// top level of the midi track note pairer: parser, request queue, stack engine
// depends on mtnp_pkg, mtnp_front, mtnp_queue, mtnp_back
//
// channel   direction  handshake              payload
// input     in         in_valid / in_ready    data_byte, track_start
// result    out        out_valid / out_ready  kind, start_tick, length, key, velocity, track_tag
// config    in         wr_en                  wr_data (track number)
//
// one byte per cycle sustained while the queue is not full; a result shows on out_valid once
// its byte has passed the queue write, the engine read and the result register
// after reset and after every track_start the fill memory is swept over all KEY_POSITIONS,
// one stack a cycle; bytes keep arriving into the four-entry queue until it fills
// a stalled result freezes the stack engine only; the parser runs until the queue is full

module midi_track_note_pairer
#(
    parameter int STACK_DEPTH = mtnp_pkg::STACK_DEPTH_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        track_start,
    input  logic        wr_en,
    input  logic [11:0] wr_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  kind,
    output logic [55:0] start_tick,
    output logic [31:0] length,
    output logic [7:0]  key,
    output logic [6:0]  velocity,
    output logic [15:0] track_tag
);

    logic [11:0]          track_number_reg;
    logic                 q_push, q_pop, q_full, q_empty;
    mtnp_pkg::op_t        q_din, q_dout;
    logic [$clog2(mtnp_pkg::QUEUE_DEPTH+1)-1:0] q_count;
    mtnp_pkg::back_stat_t stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            track_number_reg <= 12'd2;
        else if (wr_en)
            track_number_reg <= wr_data;
    end

    mtnp_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .track_start  (track_start),
        .track_number (track_number_reg),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_op         (q_din)
    );

    mtnp_queue u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_din),
        .pop   (q_pop),
        .dout  (q_dout),
        .full  (q_full),
        .empty (q_empty),
        .count (q_count)
    );

    mtnp_back #(.STACK_DEPTH(STACK_DEPTH)) u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (!q_empty),
        .q_op       (q_dout),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .kind       (kind),
        .start_tick (start_tick),
        .length     (length),
        .key        (key),
        .velocity   (velocity),
        .track_tag  (track_tag),
        .stat       (stat)
    );

    a_no_pop_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        stat.clearing |-> !stat.popping)
        else $error("request taken during fill sweep");

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= ($clog2(mtnp_pkg::QUEUE_DEPTH+1))'(mtnp_pkg::QUEUE_DEPTH))
        else $error("queue count out of range");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (kind == mtnp_pkg::KIND_NOTE || kind == mtnp_pkg::KIND_TEMPO ||
                       kind == mtnp_pkg::KIND_END || kind == mtnp_pkg::KIND_DROP ||
                       kind == mtnp_pkg::KIND_BAD))
        else $error("bad result kind");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !in_ready)
        else $error("byte taken with full queue");

endmodule
